// ----- design/udiv64_pkg.sv -----
// Shared constants and types for the 64-bit unsigned divider.
package udiv64_pkg;

  localparam int unsigned FIELD_WIDTH = 64;
  localparam int unsigned DATA_WIDTH_DEFAULT = 64;

  // Control bits that travel alongside each operand pair down the chain.
  typedef struct packed {
    logic valid;
    logic dz;
  } ctl_t;

endpackage

// ----- design/unsigned_divider_64.sv -----
// Top level of the pipelined 64-bit unsigned restoring divider.
//
// Usage: an operand pair (dividend, divisor) is offered on the op channel and
// is transferred when op_valid and op_ready are both high at a rising edge.
// The result (quotient, remainder, divide_by_zero) leaves on the res channel,
// transferred when res_valid and res_ready are both high.
// The datapath is a chain of DATA_WIDTH identical cells (capped at 64, the
// width of the operand ports); each cell resolves one quotient bit, from the
// most significant down, and registers its partial remainder for the next.
// An operand pair passes through the cells and then the output register in
// order: the transferring edge loads the first cell, each advance of the
// chain moves it one cell on, and from the last cell it is loaded into the
// output register, where it raises res_valid.
// Throughput: one division every cycle while op_ready is high, since every
// cell works on a different operand pair.
// A zero divisor raises divide_by_zero, returns an all-ones quotient and
// hands the dividend back as the remainder.
// Reset (rst, synchronous) empties the chain and the output stage.
// When the receiver stalls, the output register holds its result, one more
// result settles in a skid register, and then op_ready falls and the chain
// holds still until the receiver takes a result again.
module unsigned_divider_64 #(
  parameter int unsigned DATA_WIDTH = udiv64_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               op_valid,
  output logic                               op_ready,
  input  logic [udiv64_pkg::FIELD_WIDTH-1:0] dividend,
  input  logic [udiv64_pkg::FIELD_WIDTH-1:0] divisor,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic [udiv64_pkg::FIELD_WIDTH-1:0] quotient,
  output logic [udiv64_pkg::FIELD_WIDTH-1:0] remainder,
  output logic                               divide_by_zero
);

  // Effective operand width: widths beyond the port width behave as the
  // port width, and bits above a narrower width are ignored.
  localparam int unsigned EW = (DATA_WIDTH > udiv64_pkg::FIELD_WIDTH) ?
                               udiv64_pkg::FIELD_WIDTH : DATA_WIDTH;

  logic                en;
  udiv64_pkg::ctl_t    ctl_s [0:EW];
  logic [EW-1:0]       num_s [0:EW];
  logic [EW-1:0]       den_s [0:EW];
  logic [EW-1:0]       rem_s [0:EW];
  logic [EW-1:0]       quo_s [0:EW];

  // The chain advances as a whole whenever the output side has room, so
  // op_ready follows directly from the registered skid state.
  assign op_ready = en;

  // Head of the chain: masked operands, an empty partial remainder and the
  // zero-divisor flag worked out once here.
  assign ctl_s[0] = '{valid: op_valid, dz: (divisor[EW-1:0] == '0)};
  assign num_s[0] = dividend[EW-1:0];
  assign den_s[0] = divisor[EW-1:0];
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;

  // Cell k resolves quotient bit EW-1-k.
  for (genvar k = 0; k < EW; k++) begin : g_cell
    udiv64_cell #(
      .W   (EW),
      .BIT (EW - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_in (ctl_s[k]),
      .num_in (num_s[k]),
      .den_in (den_s[k]),
      .rem_in (rem_s[k]),
      .quo_in (quo_s[k]),
      .ctl    (ctl_s[k+1]),
      .num    (num_s[k+1]),
      .den    (den_s[k+1]),
      .rem    (rem_s[k+1]),
      .quo    (quo_s[k+1])
    );
  end

  // The divisor leaving the last cell is no longer needed.
  udiv64_out #(
    .W (EW)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .ctl_in         (ctl_s[EW]),
    .num_in         (num_s[EW]),
    .rem_in         (rem_s[EW]),
    .quo_in         (quo_s[EW]),
    .en             (en),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

endmodule

// ----- design/udiv64_cell.sv -----
// One restoring division step with its pipeline register.
module udiv64_cell #(
  parameter int unsigned W   = 64,
  parameter int unsigned BIT = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  udiv64_pkg::ctl_t     ctl_in,
  input  logic [W-1:0]         num_in,
  input  logic [W-1:0]         den_in,
  input  logic [W-1:0]         rem_in,
  input  logic [W-1:0]         quo_in,
  output udiv64_pkg::ctl_t     ctl,
  output logic [W-1:0]         num,
  output logic [W-1:0]         den,
  output logic [W-1:0]         rem,
  output logic [W-1:0]         quo
);

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         ge;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;

  // Bring down the next dividend bit and try the subtraction; the borrow out
  // of the widened difference decides the quotient bit.
  always_comb begin
    shifted  = {rem_in, num_in[BIT]};
    diff     = {1'b0, shifted} - {2'b00, den_in};
    ge       = ~diff[W+1];
    rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_next = {quo_in[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= num_in;
      den <= den_in;
      rem <= rem_next;
      quo <= quo_next;
    end
  end

endmodule

// ----- design/udiv64_out.sv -----
// Result formatting, output register and skid stage of the divider.
module udiv64_out #(
  parameter int unsigned W = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  udiv64_pkg::ctl_t                   ctl_in,
  input  logic [W-1:0]                       num_in,
  input  logic [W-1:0]                       rem_in,
  input  logic [W-1:0]                       quo_in,
  output logic                               en,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic [udiv64_pkg::FIELD_WIDTH-1:0] quotient,
  output logic [udiv64_pkg::FIELD_WIDTH-1:0] remainder,
  output logic                               divide_by_zero
);

  localparam int unsigned FW = udiv64_pkg::FIELD_WIDTH;

  logic          take;
  logic [FW-1:0] quo_fmt;
  logic [FW-1:0] rem_fmt;
  logic          skid_valid;
  logic [FW-1:0] skid_quo;
  logic [FW-1:0] skid_rem;
  logic          skid_dz;

  // A zero divisor yields all ones and hands the dividend back.
  always_comb begin
    quo_fmt = ctl_in.dz ? FW'({W{1'b1}}) : FW'(quo_in);
    rem_fmt = ctl_in.dz ? FW'(num_in) : FW'(rem_in);
  end

  assign en   = ~skid_valid;
  assign take = en & ctl_in.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        res_valid <= take;
      end
    end else if (!res_valid) begin
      res_valid <= take;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready && skid_valid) begin
      quotient       <= skid_quo;
      remainder      <= skid_rem;
      divide_by_zero <= skid_dz;
    end else if (take && (!res_valid || res_ready)) begin
      quotient       <= quo_fmt;
      remainder      <= rem_fmt;
      divide_by_zero <= ctl_in.dz;
    end
    if (take && res_valid && !res_ready) begin
      skid_quo <= quo_fmt;
      skid_rem <= rem_fmt;
      skid_dz  <= ctl_in.dz;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(res_valid && !res_ready))
    else $error("skid stage filled without a stalled output");

  a_dz_all_ones: assert property (@(posedge clk) disable iff (rst)
    (res_valid && divide_by_zero) |-> (quotient == FW'({W{1'b1}})))
    else $error("divide-by-zero result without an all-ones quotient");

endmodule
